[hdl/lzss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_pkg
// Shared types and constants of the lzss stream decompressor.
// ----------------------------------------------------------------------------
package lzss_pkg;

    localparam int DEF_WINDOW_DEPTH = 2048;
    localparam int DEF_SIZE_BITS    = 24;
    localparam int CFG_W            = 24;
    localparam int CMD_FIFO_DEPTH   = 2;

    localparam int DIST_W    = 11;
    localparam int LEN_W     = 5;
    localparam int LEN_SHIFT = 12;
    localparam int LEN_BIAS  = 2;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_LIT_INPUT   = 3'd1;
    localparam logic [2:0] ST_LIT_SIZE    = 3'd2;
    localparam logic [2:0] ST_TRUNC_MATCH = 3'd3;
    localparam logic [2:0] ST_BAD_DIST    = 3'd4;
    localparam logic [2:0] ST_MATCH_SIZE  = 3'd5;
    localparam logic [2:0] ST_SIZE_DIFF   = 3'd6;

    typedef enum logic [2:0] {
        PH_TOKEN   = 3'b001,
        PH_LITERAL = 3'b010,
        PH_MATCH   = 3'b100
    } t_phase;

    typedef enum logic [3:0] {
        BS_IDLE = 4'b0001,
        BS_READ = 4'b0010,
        BS_EMIT = 4'b0100,
        BS_END  = 4'b1000
    } t_bstate;

    typedef struct packed {
        logic              has_data;
        logic              is_match;
        logic [7:0]        data;
        logic [DIST_W-1:0] copy_dist;
        logic [LEN_W-1:0]  len;
        logic              has_end;
        logic [2:0]        status;
    } t_cmd;

endpackage

[hdl/lzss_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss stream interfaces
// Valid/ready channels for compressed input and decompressed results.
// ----------------------------------------------------------------------------
interface lzss_in_if ();
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lzss_out_if ();
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [7:0] out_byte;
    logic [2:0] out_status;
    logic       out_last;

    modport source (output valid, output out_kind, output out_byte, output out_status,
                    output out_last, input ready);
    modport sink   (input valid, input out_kind, input out_byte, input out_status,
                    input out_last, output ready);
endinterface

[hdl/lzss_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_ram
// Generic single write, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/lzss_cmd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_cmd_fifo
// Short command queue between the token parser and the copy engine.
// ----------------------------------------------------------------------------
module lzss_cmd_fifo import lzss_pkg::*; #(
    parameter int DEPTH = CMD_FIFO_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [AW:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == (AW + 1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + (AW + 1)'(1);
            2'b01:   n_cnt = r_cnt - (AW + 1)'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

[hdl/lzss_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_front
// Token parser: tracks parse phase, size and errors, issues copy commands.
// ----------------------------------------------------------------------------
module lzss_front import lzss_pkg::*; #(
    parameter int SIZE_BITS = DEF_SIZE_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lzss_in_if.sink          i_in,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_q_full,
    output logic             o_push,
    output t_cmd             o_cmd
);

    localparam int CMP_W = ((SIZE_BITS > CFG_W) ? SIZE_BITS : CFG_W) + 1;

    t_phase                r_phase, n_phase;
    logic [6:0]            r_rem, n_rem;
    logic [7:0]            r_low, n_low;
    logic [SIZE_BITS-1:0]  r_prod, n_prod;
    logic [2:0]            r_err, n_err;
    logic [CFG_W-1:0]      r_exp;

    logic                  w_acc;
    logic [7:0]            w_b;
    logic                  w_last;
    logic [CMP_W-1:0]      w_prod, w_exp, w_room;
    logic [15:0]           w_word;
    logic [DIST_W-1:0]     w_dist;
    logic [LEN_W-1:0]      w_mlen;
    logic [6:0]            w_llen;
    t_cmd                  w_cmd;

    assign i_in.ready = !i_q_full;
    assign w_acc      = i_in.valid && !i_q_full;
    assign w_b        = i_in.in_byte;
    assign w_last     = i_in.in_last;

    assign w_prod = CMP_W'(r_prod);
    assign w_exp  = CMP_W'(r_exp);
    assign w_room = (w_prod >= w_exp) ? '0 : w_exp - w_prod;

    assign w_word = {w_b, r_low};
    assign w_dist = w_word[DIST_W:1];
    assign w_mlen = LEN_W'(w_word[15:LEN_SHIFT]) + LEN_W'(LEN_BIAS);
    assign w_llen = w_b[7:1];

    always_comb begin
        n_phase = r_phase;
        n_rem   = r_rem;
        n_low   = r_low;
        n_prod  = r_prod;
        n_err   = r_err;
        w_cmd   = '0;
        if (w_acc) begin
            if (r_err == ST_OK) begin
                case (r_phase)
                    PH_LITERAL: begin
                        w_cmd.has_data = 1'b1;
                        w_cmd.data     = w_b;
                        n_prod         = r_prod + SIZE_BITS'(1);
                        n_rem          = r_rem - 7'd1;
                        if (r_rem == 7'd1) begin
                            n_phase = PH_TOKEN;
                        end else if (w_last) begin
                            n_err = ST_LIT_INPUT;
                        end
                    end
                    PH_MATCH: begin
                        n_phase = PH_TOKEN;
                        if (w_dist == '0 || CMP_W'(w_dist) > w_prod) begin
                            n_err = ST_BAD_DIST;
                        end else if (CMP_W'(w_mlen) > w_room) begin
                            n_err = ST_MATCH_SIZE;
                        end else begin
                            w_cmd.has_data  = 1'b1;
                            w_cmd.is_match  = 1'b1;
                            w_cmd.copy_dist = w_dist;
                            w_cmd.len       = w_mlen;
                            n_prod          = r_prod + SIZE_BITS'(w_mlen);
                        end
                    end
                    default: begin
                        if (!w_b[0]) begin
                            if (CMP_W'(w_llen) > w_room) begin
                                n_err = ST_LIT_SIZE;
                            end else if (w_last && w_llen != '0) begin
                                n_err = ST_LIT_INPUT;
                            end else if (w_llen != '0) begin
                                n_rem   = w_llen;
                                n_phase = PH_LITERAL;
                            end else begin
                                n_phase = PH_TOKEN;
                            end
                        end else if (w_last) begin
                            n_err = ST_TRUNC_MATCH;
                        end else begin
                            n_low   = w_b;
                            n_phase = PH_MATCH;
                        end
                    end
                endcase
            end
            if (w_last) begin
                w_cmd.has_end = 1'b1;
                if (n_err != ST_OK) begin
                    w_cmd.status = n_err;
                end else if (n_phase == PH_LITERAL) begin
                    w_cmd.status = ST_LIT_INPUT;
                end else if (n_phase == PH_MATCH) begin
                    w_cmd.status = ST_TRUNC_MATCH;
                end else if (CMP_W'(n_prod) != w_exp) begin
                    w_cmd.status = ST_SIZE_DIFF;
                end else begin
                    w_cmd.status = ST_OK;
                end
                n_phase = PH_TOKEN;
                n_rem   = '0;
                n_low   = '0;
                n_prod  = '0;
                n_err   = ST_OK;
            end
        end
    end

    assign o_push = w_cmd.has_data || w_cmd.has_end;
    assign o_cmd  = w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TOKEN;
            r_rem   <= '0;
            r_low   <= '0;
            r_prod  <= '0;
            r_err   <= ST_OK;
            r_exp   <= CFG_W'(1);
        end else begin
            r_phase <= n_phase;
            r_rem   <= n_rem;
            r_low   <= n_low;
            r_prod  <= n_prod;
            r_err   <= n_err;
            if (i_cfg_we) begin
                r_exp <= i_cfg_wdata;
            end
        end
    end

endmodule

[hdl/lzss_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_back
// Copy engine: emits literals and back-references, keeps the history window.
// ----------------------------------------------------------------------------
module lzss_back import lzss_pkg::*; #(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_empty,
    output logic        o_pop,
    lzss_out_if.source  o_out
);

    localparam int AW = $clog2(WINDOW_DEPTH);

    t_bstate          r_state, n_state;
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_src, n_src;
    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic             r_has_end, n_has_end;
    logic [2:0]       r_status, n_status;

    logic             r_valid;
    logic             r_kind;
    logic [7:0]       r_byte;
    logic [2:0]       r_ostat;
    logic             r_olast;

    logic             w_free;
    logic             w_ld;
    logic             w_ld_kind;
    logic [7:0]       w_ld_byte;
    logic [2:0]       w_ld_stat;
    logic             w_ld_last;
    logic             w_ram_we;
    logic             w_ram_re;
    logic [7:0]       w_ram_rd;
    logic [AW:0]      w_diff;
    logic [AW-1:0]    w_start;
    logic [AW-1:0]    w_wr_inc;
    logic [AW-1:0]    w_src_inc;

    assign w_free    = !r_valid || o_out.ready;
    assign w_diff    = {1'b0, r_wr} - (AW + 1)'(i_cmd.copy_dist);
    assign w_start   = w_diff[AW] ? AW'(w_diff + (AW + 1)'(WINDOW_DEPTH)) : w_diff[AW-1:0];
    assign w_wr_inc  = (r_wr == AW'(WINDOW_DEPTH - 1)) ? '0 : r_wr + AW'(1);
    assign w_src_inc = (r_src == AW'(WINDOW_DEPTH - 1)) ? '0 : r_src + AW'(1);

    lzss_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wr),
        .i_wdata (w_ld_byte),
        .i_re    (w_ram_re),
        .i_raddr (r_src),
        .o_rdata (w_ram_rd)
    );

    always_comb begin
        n_state   = r_state;
        n_wr      = r_wr;
        n_src     = r_src;
        n_cnt     = r_cnt;
        n_has_end = r_has_end;
        n_status  = r_status;
        o_pop     = 1'b0;
        w_ld      = 1'b0;
        w_ld_kind = KIND_DATA;
        w_ld_byte = '0;
        w_ld_stat = ST_OK;
        w_ld_last = 1'b0;
        w_ram_we  = 1'b0;
        w_ram_re  = 1'b0;
        case (r_state)
            BS_IDLE: begin
                if (!i_empty) begin
                    if (i_cmd.has_data && !i_cmd.is_match) begin
                        if (w_free) begin
                            w_ld      = 1'b1;
                            w_ld_byte = i_cmd.data;
                            w_ld_last = !i_cmd.has_end;
                            w_ram_we  = 1'b1;
                            n_wr      = w_wr_inc;
                            o_pop     = 1'b1;
                            if (i_cmd.has_end) begin
                                n_status = i_cmd.status;
                                n_state  = BS_END;
                            end
                        end
                    end else if (i_cmd.has_data) begin
                        o_pop     = 1'b1;
                        n_src     = w_start;
                        n_cnt     = i_cmd.len;
                        n_has_end = i_cmd.has_end;
                        n_status  = i_cmd.status;
                        n_state   = BS_READ;
                    end else if (w_free) begin
                        w_ld      = 1'b1;
                        w_ld_kind = KIND_END;
                        w_ld_stat = i_cmd.status;
                        w_ld_last = 1'b1;
                        n_wr      = '0;
                        o_pop     = 1'b1;
                    end
                end
            end
            BS_READ: begin
                w_ram_re = 1'b1;
                n_state  = BS_EMIT;
            end
            BS_EMIT: begin
                w_ld_byte = w_ram_rd;
                if (w_free) begin
                    w_ld      = 1'b1;
                    w_ld_last = (r_cnt == LEN_W'(1)) && !r_has_end;
                    w_ram_we  = 1'b1;
                    n_wr      = w_wr_inc;
                    n_src     = w_src_inc;
                    n_cnt     = r_cnt - LEN_W'(1);
                    if (r_cnt == LEN_W'(1)) begin
                        n_state = r_has_end ? BS_END : BS_IDLE;
                    end else begin
                        n_state = BS_READ;
                    end
                end
            end
            BS_END: begin
                if (w_free) begin
                    w_ld      = 1'b1;
                    w_ld_kind = KIND_END;
                    w_ld_stat = r_status;
                    w_ld_last = 1'b1;
                    n_wr      = '0;
                    n_state   = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_kind  <= w_ld_kind;
            r_byte  <= w_ld_byte;
            r_ostat <= w_ld_stat;
            r_olast <= w_ld_last;
        end
        r_src     <= n_src;
        r_cnt     <= n_cnt;
        r_status  <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_IDLE;
            r_wr      <= '0;
            r_has_end <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wr      <= n_wr;
            r_has_end <= n_has_end;
            if (w_ld) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.out_kind   = r_kind;
    assign o_out.out_byte   = r_byte;
    assign o_out.out_status = r_ostat;
    assign o_out.out_last   = r_olast;

endmodule

[hdl/lzss_stream_decompressor_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_stream_decompressor_unit
// Byte-stream lzss decompressor with a history window and end status.
//
//   channel  dir  signals                                   request
//   i_in     in   in_byte, in_last                          one compressed byte
//   o_out    out  out_kind, out_byte, out_status, out_last  one result
//   cfg      in   i_cfg_we, i_cfg_wdata                     expected size write
//
// token and literal bytes are accepted whenever the command queue is not full
// a back-reference is popped from the queue; each copied byte then takes a
// registered window read, then a write and emit that waits for the output
// a two-entry command queue lets input run ahead of the copy engine
// synchronous active-low reset; the window is not cleared
// ----------------------------------------------------------------------------
module lzss_stream_decompressor_unit import lzss_pkg::*; #(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
    parameter int SIZE_BITS    = DEF_SIZE_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    lzss_in_if.sink          i_in,
    lzss_out_if.source       o_out
);

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_cmd w_cmd_in;
    t_cmd w_cmd_out;

    lzss_front #(
        .SIZE_BITS (SIZE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_cmd       (w_cmd_in)
    );

    lzss_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out),
        .o_empty (w_empty)
    );

    lzss_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd_out),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
